// ===== rtl/cpp_pkg.sv =====
// cpp_pkg: shared widths, codes and control structs of the clipmap piece placer
// used by the channel interfaces, cpp_ctrl, cpp_datapath and clipmap_piece_placer
package cpp_pkg;

  // fixed field widths
  localparam int POS_W      = 24;  // camera position, Q15.8
  localparam int ORG_W      = 25;  // piece origin, Q16.8
  localparam int CALC_W     = 28;  // headroom for origin sums
  localparam int SQ_W       = 2 * ORG_W;
  localparam int SB_W       = $clog2(POS_W);
  localparam int RING_W     = 7;
  localparam int LVLCNT_W   = 3;
  localparam int LVL_W      = 2;
  localparam int IDX_W      = 6;
  localparam int KIND_W     = 3;
  localparam int ROT_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam int MAX_LEVELS_DEF = 4;
  localparam int FRAC_BITS_DEF  = 8;

  localparam logic [RING_W-1:0]   RING_RESET   = 7'd48;
  localparam logic [LVLCNT_W-1:0] LVLCNT_RESET = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE = 2'd0,
    CFG_RING   = 2'd1,
    CFG_LEVELS = 2'd2
  } cfg_reg_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_CROSS  = 3'd0,
    KIND_TILE   = 3'd1,
    KIND_FILLER = 3'd2,
    KIND_TRIM   = 3'd3,
    KIND_SEAM   = 3'd4
  } piece_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Z,
    ST_SQ_H,
    ST_CMP,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic              capture;
    logic              sq_x;
    logic              sq_z;
    logic              sq_h;
    logic              snap_store;
    logic              emit;
    piece_kind_e       kind;
    logic [1:0]        i;
    logic [1:0]        j;
    logic [LVL_W-1:0]  lvl;
    logic [IDX_W-1:0]  index;
    logic              last;
  } cpp_cmd_t;

  typedef struct packed {
    logic              active;
    logic              held;
    logic              far;
    logic              slot_free;
    logic [LVL_W-1:0]  last_level;
  } cpp_stat_t;

endpackage

// ===== rtl/cpp_if.sv =====
// cpp_if: valid/ready channel interfaces for camera positions and piece placements
// depends on cpp_pkg for the payload widths
interface cpp_cam_if;
  logic                              valid;
  logic                              ready;
  logic signed [cpp_pkg::POS_W-1:0]  cam_x;
  logic signed [cpp_pkg::POS_W-1:0]  cam_z;

  modport source (output valid, output cam_x, output cam_z, input ready);
  modport sink   (input valid, input cam_x, input cam_z, output ready);
endinterface

interface cpp_place_if;
  logic                               valid;
  logic                               ready;
  logic [cpp_pkg::KIND_W-1:0]         piece_kind;
  logic [cpp_pkg::IDX_W-1:0]          piece_index;
  logic [cpp_pkg::LVL_W-1:0]          level;
  logic signed [cpp_pkg::ORG_W-1:0]   origin_x;
  logic signed [cpp_pkg::ORG_W-1:0]   origin_z;
  logic [cpp_pkg::LVL_W-1:0]          scale_log2;
  logic [cpp_pkg::ROT_W-1:0]          rotation;
  logic                               last;

  modport source (output valid, output piece_kind, output piece_index, output level,
                  output origin_x, output origin_z, output scale_log2, output rotation,
                  output last, input ready);
  modport sink   (input valid, input piece_kind, input piece_index, input level,
                  input origin_x, input origin_z, input scale_log2, input rotation,
                  input last, output ready);
endinterface

// ===== rtl/cpp_ctrl.sv =====
// cpp_ctrl: controller of the piece placer, sequences the distance check and
// walks the pieces in emission order; depends on cpp_pkg
module cpp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cpp_pkg::cpp_stat_t stat_i,
  output cpp_pkg::cpp_cmd_t  cmd_o
);
  import cpp_pkg::*;

  ctrl_state_e       state_q, state_d;
  piece_kind_e       kind_q, kind_d;
  logic [3:0]        ij_q, ij_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic [IDX_W-1:0]  tile_q, tile_d;

  logic snap_go;
  logic emit_fire;
  logic is_last;
  logic mid_row;

  assign snap_go   = stat_i.far || !stat_i.held;
  assign emit_fire = (state_q == ST_EMIT) && stat_i.slot_free;
  assign is_last   = (kind_q == KIND_FILLER) && (lvl_q == stat_i.last_level);
  // inner rows of the grid skip the center columns above level zero
  assign mid_row   = (lvl_q != '0) && ((ij_q[3:2] == 2'd1) || (ij_q[3:2] == 2'd2)) &&
                     (ij_q[1:0] == 2'd0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && stat_i.active) state_d = ST_SQ_X;
      end
      ST_SQ_X: state_d = ST_SQ_Z;
      ST_SQ_Z: state_d = ST_SQ_H;
      ST_SQ_H: state_d = ST_CMP;
      ST_CMP: begin
        state_d = snap_go ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (emit_fire && is_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.capture    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.sq_x       = (state_q == ST_SQ_X);
    cmd_o.sq_z       = (state_q == ST_SQ_Z);
    cmd_o.sq_h       = (state_q == ST_SQ_H);
    cmd_o.snap_store = (state_q == ST_CMP) && snap_go;
    cmd_o.emit       = emit_fire;
    cmd_o.kind       = kind_q;
    cmd_o.i          = ij_q[3:2];
    cmd_o.j          = ij_q[1:0];
    cmd_o.lvl        = lvl_q;
    cmd_o.index      = (kind_q == KIND_TILE) ? tile_q : IDX_W'(lvl_q);
    cmd_o.last       = is_last;
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    kind_d = kind_q;
    ij_d   = ij_q;
    lvl_d  = lvl_q;
    tile_d = tile_q;
    if (state_q == ST_CMP) begin
      kind_d = KIND_CROSS;
      ij_d   = '0;
      lvl_d  = '0;
      tile_d = '0;
    end else if (emit_fire) begin
      case (kind_q)
        KIND_CROSS: begin
          kind_d = KIND_TILE;
          ij_d   = '0;
        end
        KIND_TILE: begin
          tile_d = tile_q + IDX_W'(1);
          if (ij_q == 4'hF) begin
            kind_d = KIND_FILLER;
          end else if (mid_row) begin
            ij_d = ij_q + 4'd3;
          end else begin
            ij_d = ij_q + 4'd1;
          end
        end
        KIND_FILLER: kind_d = KIND_TRIM;
        KIND_TRIM:   kind_d = KIND_SEAM;
        KIND_SEAM: begin
          kind_d = KIND_TILE;
          ij_d   = '0;
          lvl_d  = lvl_q + LVL_W'(1);
        end
        default: kind_d = KIND_CROSS;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kind_q  <= KIND_CROSS;
      ij_q    <= '0;
      lvl_q   <= '0;
      tile_q  <= '0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      ij_q    <= ij_d;
      lvl_q   <= lvl_d;
      tile_q  <= tile_d;
    end
  end

endmodule

// ===== rtl/cpp_datapath.sv =====
// cpp_datapath: configuration registers, snap state, shared squaring multiplier,
// piece origin arithmetic and the output register; depends on cpp_pkg
module cpp_datapath #(
  parameter int MAX_LEVELS = cpp_pkg::MAX_LEVELS_DEF,
  parameter int FRAC_BITS  = cpp_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [cpp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cpp_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic signed [cpp_pkg::POS_W-1:0]   cam_x_i,
  input  logic signed [cpp_pkg::POS_W-1:0]   cam_z_i,
  input  cpp_pkg::cpp_cmd_t                  cmd_i,
  output cpp_pkg::cpp_stat_t                 stat_o,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [cpp_pkg::KIND_W-1:0]         piece_kind_o,
  output logic [cpp_pkg::IDX_W-1:0]          piece_index_o,
  output logic [cpp_pkg::LVL_W-1:0]          level_o,
  output logic signed [cpp_pkg::ORG_W-1:0]   origin_x_o,
  output logic signed [cpp_pkg::ORG_W-1:0]   origin_z_o,
  output logic [cpp_pkg::LVL_W-1:0]          scale_log2_o,
  output logic [cpp_pkg::ROT_W-1:0]          rotation_o,
  output logic                               last_o
);
  import cpp_pkg::*;

  function automatic logic signed [CALC_W-1:0] ext_pos(logic [POS_W-1:0] v);
    return CALC_W'($signed(v));
  endfunction

  // configuration
  logic                 active_q;
  logic [RING_W-1:0]    ring_q;
  logic [LVLCNT_W-1:0]  lvlcnt_q;
  logic [LVL_W-1:0]     last_level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ring_q   <= RING_RESET;
      lvlcnt_q <= LVLCNT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACTIVE: active_q <= cfg_data_i[0];
        CFG_RING:   ring_q   <= cfg_data_i[RING_W-1:0];
        CFG_LEVELS: lvlcnt_q <= cfg_data_i[LVLCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero levels act as one, too many saturate
  always_comb begin
    if (lvlcnt_q == '0) begin
      last_level = '0;
    end else if (lvlcnt_q > LVLCNT_W'(MAX_LEVELS)) begin
      last_level = LVL_W'(MAX_LEVELS - 1);
    end else begin
      last_level = LVL_W'(lvlcnt_q - LVLCNT_W'(1));
    end
  end

  // camera and snap position
  logic [POS_W-1:0] cam_x_q, cam_z_q;
  logic [POS_W-1:0] snap_x_q, snap_z_q;
  logic             held_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cam_x_q <= cam_x_i;
      cam_z_q <= cam_z_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_x_q <= '0;
      snap_z_q <= '0;
      held_q   <= 1'b0;
    end else if (cmd_i.snap_store) begin
      snap_x_q <= cam_x_q;
      snap_z_q <= cam_z_q;
      held_q   <= 1'b1;
    end
  end

  // squared distance against (ring_size/2)^2, one square per cycle
  logic signed [ORG_W-1:0] dx, dz, half, mul_op;
  logic signed [SQ_W-1:0]  prod_d, prod_q;
  logic [SQ_W-1:0]         sum_q;

  assign dx   = $signed({cam_x_q[POS_W-1], cam_x_q}) - $signed({snap_x_q[POS_W-1], snap_x_q});
  assign dz   = $signed({cam_z_q[POS_W-1], cam_z_q}) - $signed({snap_z_q[POS_W-1], snap_z_q});
  assign half = $signed({{(ORG_W-RING_W){1'b0}}, ring_q} << (FRAC_BITS - 1));

  always_comb begin
    if (cmd_i.sq_x) begin
      mul_op = dx;
    end else if (cmd_i.sq_z) begin
      mul_op = dz;
    end else begin
      mul_op = half;
    end
  end

  assign prod_d = mul_op * mul_op;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_x || cmd_i.sq_z || cmd_i.sq_h) prod_q <= prod_d;
    if (cmd_i.sq_z) sum_q <= $unsigned(prod_q);
    if (cmd_i.sq_h) sum_q <= sum_q + $unsigned(prod_q);
  end

  // piece origins
  logic [SB_W-1:0]          sb, sb_n;
  logic [POS_W-1:0]         low_l, low_n;
  logic signed [CALC_W-1:0] fx, fz, fnx, fnz, big, s_unit, off_x, off_z, ox, oz;
  logic [ROT_W-1:0]         rot;

  assign sb     = SB_W'(FRAC_BITS) + SB_W'(cmd_i.lvl);
  assign sb_n   = sb + SB_W'(1);
  assign low_l  = (POS_W'(1) << sb) - POS_W'(1);
  assign low_n  = (POS_W'(1) << sb_n) - POS_W'(1);
  assign fx     = ext_pos(cam_x_q & ~low_l);
  assign fz     = ext_pos(cam_z_q & ~low_l);
  assign fnx    = ext_pos(cam_x_q & ~low_n);
  assign fnz    = ext_pos(cam_z_q & ~low_n);
  assign big    = $signed(CALC_W'(ring_q) << sb);
  assign s_unit = $signed(CALC_W'(1) << sb);

  // grid column offset from the floor: -2S, -S, +s, S+s
  always_comb begin
    case (cmd_i.i)
      2'd0:    off_x = -(big <<< 1);
      2'd1:    off_x = -big;
      2'd2:    off_x = s_unit;
      default: off_x = big + s_unit;
    endcase
    case (cmd_i.j)
      2'd0:    off_z = -(big <<< 1);
      2'd1:    off_z = -big;
      2'd2:    off_z = s_unit;
      default: off_z = big + s_unit;
    endcase
  end

  always_comb begin
    rot = '0;
    unique case (cmd_i.kind) inside
      KIND_CROSS, KIND_FILLER: begin
        ox = fx;
        oz = fz;
      end
      KIND_TILE: begin
        ox = fx + off_x;
        oz = fz + off_z;
      end
      KIND_TRIM: begin
        ox  = fx + (s_unit >>> 1);
        oz  = fz + (s_unit >>> 1);
        // camera in the lower half of the next level cell
        rot = {~cam_x_q[sb], ~cam_z_q[sb]};
      end
      KIND_SEAM: begin
        ox = fnx - (big <<< 1);
        oz = fnz - (big <<< 1);
      end
      default: begin
        ox = fx;
        oz = fz;
      end
    endcase
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      piece_kind_o  <= cmd_i.kind;
      piece_index_o <= cmd_i.index;
      level_o       <= cmd_i.lvl;
      origin_x_o    <= ox[ORG_W-1:0];
      origin_z_o    <= oz[ORG_W-1:0];
      scale_log2_o  <= cmd_i.lvl;
      rotation_o    <= rot;
      last_o        <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;

  assign stat_o.active     = active_q;
  assign stat_o.held       = held_q;
  assign stat_o.far        = sum_q > $unsigned(prod_q);
  assign stat_o.slot_free  = !out_valid_q || out_ready_i;
  assign stat_o.last_level = last_level;

endmodule

// ===== rtl/clipmap_piece_placer.sv =====
// clipmap_piece_placer: top level, joins cpp_ctrl and cpp_datapath to the channels
// depends on cpp_pkg, cpp_cam_if, cpp_place_if, cpp_ctrl and cpp_datapath
// Check: a position is squared on the shared squaring multiplier in ST_SQ_X, ST_SQ_Z
// and ST_SQ_H and compared in ST_CMP; on a re-snap the first placement is then
// registered in ST_EMIT. Throughput: one placement per cycle unless the output stalls;
// a re-snap emits up to 63 placements, and a new position is accepted only in ST_IDLE.
// Reset: asynchronous active low; clears snap state, restores register defaults.
module clipmap_piece_placer #(
  parameter int MAX_LEVELS = cpp_pkg::MAX_LEVELS_DEF,
  parameter int FRAC_BITS  = cpp_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cpp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cpp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  cpp_cam_if.sink                         cam_i,
  cpp_place_if.source                     place_o
);
  import cpp_pkg::*;

  cpp_cmd_t  cmd;
  cpp_stat_t stat;

  cpp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cam_i.valid),
    .in_ready_o (cam_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cpp_datapath #(
    .MAX_LEVELS (MAX_LEVELS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cam_x_i       (cam_i.cam_x),
    .cam_z_i       (cam_i.cam_z),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (place_o.ready),
    .out_valid_o   (place_o.valid),
    .piece_kind_o  (place_o.piece_kind),
    .piece_index_o (place_o.piece_index),
    .level_o       (place_o.level),
    .origin_x_o    (place_o.origin_x),
    .origin_z_o    (place_o.origin_z),
    .scale_log2_o  (place_o.scale_log2),
    .rotation_o    (place_o.rotation),
    .last_o        (place_o.last)
  );

endmodule
